// File: src/playfair_digraph_cipher_assert.svh
// Assertion macros used by the playfair digraph cipher RTL.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pf_pkg.sv
// Types, codes and helper functions for the playfair digraph cipher.
package pf_pkg;

    localparam int SIDE  = 5;
    localparam int CELLS = 25;
    localparam int ALPHA = 26;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_t;
    typedef logic [2:0] coord_t;
    typedef logic [2:0] func_t;

    localparam func_t FUNC_CLEAR   = 3'd0;
    localparam func_t FUNC_ADD     = 3'd1;
    localparam func_t FUNC_FINISH  = 3'd2;
    localparam func_t FUNC_ENCRYPT = 3'd3;
    localparam func_t FUNC_DECRYPT = 3'd4;

    localparam letter_t LETTER_I    = 5'd8;
    localparam letter_t LETTER_J    = 5'd9;
    localparam letter_t LETTER_LAST = 5'(ALPHA - 1);
    localparam cell_t   CELL_COUNT  = 5'(CELLS);
    localparam coord_t  COORD_LAST  = 3'(SIDE - 1);

    typedef struct packed {
        func_t   func;
        letter_t letter_a;
        letter_t letter_b;
    } pf_in_t;

    typedef struct packed {
        letter_t out_a;
        letter_t out_b;
        logic    status;
    } pf_out_t;

    typedef struct packed {
        logic    sq_we;
        cell_t   sq_addr;
        letter_t sq_data;
        logic    pos_we;
        letter_t pos_addr;
        cell_t   pos_data;
    } pf_wr_t;

    typedef struct packed {
        cell_t   sq_a;
        cell_t   sq_b;
        letter_t pos_a;
        letter_t pos_b;
    } pf_rd_t;

    function automatic letter_t clamp_letter(input letter_t v);
        return (v > LETTER_LAST) ? LETTER_LAST : v;
    endfunction

    // I and J share one position entry
    function automatic letter_t fold_letter(input letter_t v);
        return (v == LETTER_J) ? LETTER_I : v;
    endfunction

    function automatic coord_t cell_row(input cell_t c);
        coord_t r;
        if (c >= 5'd20) begin
            r = 3'd4;
        end else if (c >= 5'd15) begin
            r = 3'd3;
        end else if (c >= 5'd10) begin
            r = 3'd2;
        end else if (c >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic coord_t cell_col(input cell_t c);
        coord_t r;
        cell_t  base;
        r    = cell_row(c);
        base = {r, 2'b00} + {2'b00, r};
        return 3'(c - base);
    endfunction

    function automatic cell_t make_cell(input coord_t row, input coord_t col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

    function automatic coord_t step_coord(input coord_t c, input logic back);
        coord_t r;
        if (back) begin
            r = (c == 3'd0) ? COORD_LAST : c - 3'd1;
        end else begin
            r = (c == COORD_LAST) ? 3'd0 : c + 3'd1;
        end
        return r;
    endfunction

endpackage

// File: src/playfair_digraph_cipher.sv
// Top level of the playfair digraph cipher: sequencer, key state and result register.
//
// Playfair cipher on a 5x5 key square (I and J share a cell). Each transaction on
// s_ carries a function: clear key, add key letter, finish square, encrypt pair or
// decrypt pair, and yields exactly one transaction on m_. Clear and add pass through
// decode to the result state; a pair goes through position memory read, cell
// mapping with square memory read and result capture; finishing walks all 26
// letters through the single placement unit, one letter a cycle.
// One transaction is worked on at a time; s_ready is high while the sequencer is idle,
// and a result held in the output register does not block the next acceptance.
// Pairs sent before the square is finished return status 1 and zero letters.
`include "playfair_digraph_cipher_assert.svh"

module playfair_digraph_cipher (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pf_pkg::pf_in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output pf_pkg::pf_out_t  m_data
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_FILL   = 6'b000100,
        ST_POSRD  = 6'b001000,
        ST_SQRD   = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    pf_pkg::pf_in_t    item_reg, item_next;
    logic [25:0]       used_reg, used_next;
    pf_pkg::cell_t     fill_reg, fill_next;
    logic              ready_reg, ready_next;
    pf_pkg::letter_t   walk_reg, walk_next;
    pf_pkg::pf_out_t   res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    pf_pkg::pf_out_t   m_data_reg, m_data_next;

    logic              place_en;
    pf_pkg::letter_t   place_let;
    logic              place_ok;
    pf_pkg::pf_wr_t    wr;
    pf_pkg::pf_rd_t    rd;
    pf_pkg::letter_t   sq_a_data, sq_b_data;
    pf_pkg::cell_t     pos_a_data, pos_b_data;
    pf_pkg::cell_t     cell_a, cell_b;

    pf_store u_store (
        .aclk       (aclk),
        .wr         (wr),
        .rd         (rd),
        .sq_a_data  (sq_a_data),
        .sq_b_data  (sq_b_data),
        .pos_a_data (pos_a_data),
        .pos_b_data (pos_b_data)
    );

    pf_pair_map u_pair_map (
        .pos_a   (pos_a_data),
        .pos_b   (pos_b_data),
        .decrypt (item_reg.func == pf_pkg::FUNC_DECRYPT),
        .cell_a  (cell_a),
        .cell_b  (cell_b)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // placement unit shared by add and finish
    assign place_ok = place_en && !used_reg[place_let] && (fill_reg < pf_pkg::CELL_COUNT);

    always_comb begin
        wr.sq_we    = place_ok;
        wr.sq_addr  = fill_reg;
        wr.sq_data  = place_let;
        wr.pos_we   = place_ok;
        wr.pos_addr = pf_pkg::fold_letter(place_let);
        wr.pos_data = fill_reg;
        rd.pos_a    = pf_pkg::fold_letter(item_reg.letter_a);
        rd.pos_b    = pf_pkg::fold_letter(item_reg.letter_b);
        rd.sq_a     = cell_a;
        rd.sq_b     = cell_b;
    end

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        used_next    = used_reg;
        fill_next    = fill_reg;
        ready_next   = ready_reg;
        walk_next    = walk_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        place_en     = 1'b0;
        place_let    = item_reg.letter_a;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next.func     = s_data.func;
                    item_next.letter_a = pf_pkg::clamp_letter(s_data.letter_a);
                    item_next.letter_b = pf_pkg::clamp_letter(s_data.letter_b);
                    state_next         = ST_DECODE;
                end
            end
            ST_DECODE: begin
                res_next   = '0;
                state_next = ST_RESULT;
                case (item_reg.func)
                    pf_pkg::FUNC_CLEAR: begin
                        used_next  = '0;
                        fill_next  = '0;
                        ready_next = 1'b0;
                    end
                    pf_pkg::FUNC_ADD: begin
                        place_en = !ready_reg;
                    end
                    pf_pkg::FUNC_FINISH: begin
                        if (!ready_reg) begin
                            walk_next  = '0;
                            state_next = ST_FILL;
                        end
                    end
                    pf_pkg::FUNC_ENCRYPT, pf_pkg::FUNC_DECRYPT: begin
                        if (ready_reg) begin
                            state_next = ST_POSRD;
                        end else begin
                            res_next.status = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_FILL: begin
                place_en  = 1'b1;
                place_let = walk_reg;
                walk_next = walk_reg + 5'd1;
                if (walk_reg == pf_pkg::LETTER_LAST) begin
                    ready_next = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_POSRD: begin
                state_next = ST_SQRD;
            end
            ST_SQRD: begin
                res_next.out_a  = sq_a_data;
                res_next.out_b  = sq_b_data;
                res_next.status = 1'b0;
                state_next      = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (place_ok) begin
            used_next[place_let] = 1'b1;
            if ((place_let == pf_pkg::LETTER_I) || (place_let == pf_pkg::LETTER_J)) begin
                used_next[pf_pkg::LETTER_I] = 1'b1;
                used_next[pf_pkg::LETTER_J] = 1'b1;
            end
            fill_next = fill_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            fill_reg    <= '0;
            ready_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            fill_reg    <= fill_next;
            ready_reg   <= ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        walk_reg   <= walk_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    `PF_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= pf_pkg::CELL_COUNT,
        "fill count beyond square size")
    `PF_ASSERT_NOW(a_ready_full, ready_reg, fill_reg == pf_pkg::CELL_COUNT,
        "square ready but not full")
    `PF_ASSERT_NOW(a_ready_used, ready_reg, used_reg == {26{1'b1}},
        "square ready with letters unplaced")
    `PF_ASSERT_NEXT(a_drain, m_valid_reg && m_ready && (state_reg != ST_RESULT),
        !m_valid_reg, "result repeated after transaction")
    `PF_ASSERT_NEXT(a_fill_exit, state_reg == ST_FILL,
        (state_reg == ST_FILL) || (state_reg == ST_RESULT), "fill walk left early")

endmodule

// File: src/pf_store.sv
// Key square and letter position memories with registered reads.
module pf_store (
    input  logic             aclk,
    input  pf_pkg::pf_wr_t   wr,
    input  pf_pkg::pf_rd_t   rd,
    output pf_pkg::letter_t  sq_a_data,
    output pf_pkg::letter_t  sq_b_data,
    output pf_pkg::cell_t    pos_a_data,
    output pf_pkg::cell_t    pos_b_data
);

    pf_pkg::letter_t square_mem [pf_pkg::CELLS];
    pf_pkg::cell_t   pos_mem    [pf_pkg::ALPHA];

    always_ff @(posedge aclk) begin
        if (wr.sq_we) begin
            square_mem[wr.sq_addr] <= wr.sq_data;
        end
        sq_a_data <= square_mem[rd.sq_a];
        sq_b_data <= square_mem[rd.sq_b];
    end

    always_ff @(posedge aclk) begin
        if (wr.pos_we) begin
            pos_mem[wr.pos_addr] <= wr.pos_data;
        end
        pos_a_data <= pos_mem[rd.pos_a];
        pos_b_data <= pos_mem[rd.pos_b];
    end

endmodule

// File: src/pf_pair_map.sv
// Digraph cell mapping: row shift, column shift or column swap.
module pf_pair_map (
    input  pf_pkg::cell_t pos_a,
    input  pf_pkg::cell_t pos_b,
    input  logic          decrypt,
    output pf_pkg::cell_t cell_a,
    output pf_pkg::cell_t cell_b
);

    pf_pkg::coord_t r1, c1, r2, c2;
    pf_pkg::coord_t nr1, nc1, nr2, nc2;

    always_comb begin
        r1  = pf_pkg::cell_row(pos_a);
        c1  = pf_pkg::cell_col(pos_a);
        r2  = pf_pkg::cell_row(pos_b);
        c2  = pf_pkg::cell_col(pos_b);
        nr1 = r1;
        nc1 = c1;
        nr2 = r2;
        nc2 = c2;
        if (r1 == r2) begin
            nc1 = pf_pkg::step_coord(c1, decrypt);
            nc2 = pf_pkg::step_coord(c2, decrypt);
        end else if (c1 == c2) begin
            nr1 = pf_pkg::step_coord(r1, decrypt);
            nr2 = pf_pkg::step_coord(r2, decrypt);
        end else begin
            nc1 = c2;
            nc2 = c1;
        end
        cell_a = pf_pkg::make_cell(nr1, nc1);
        cell_b = pf_pkg::make_cell(nr2, nc2);
    end

endmodule

// File: tb/playfair_cipher_checker.sv
// Checker for the playfair digraph cipher: tracks the key square, predicts and compares results.
`timescale 1ns / 100ps

module playfair_cipher_checker (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_ready,
    input  pf_pkg::pf_in_t  s_data,
    input  logic            m_valid,
    input  logic            m_ready,
    input  pf_pkg::pf_out_t m_data,
    output int              fail_count,
    output int              pending
);

    localparam int PRINT_LIMIT = 50;

    pf_pkg::letter_t          square_letter [pf_pkg::CELLS];
    pf_pkg::cell_t            letter_cell [pf_pkg::ALPHA];
    logic [pf_pkg::ALPHA-1:0] placed;
    int                       filled;
    logic                     square_done;
    pf_pkg::pf_out_t          expected_out [$];
    int                       result_count;

    task automatic report_mismatch(input string field, input logic [4:0] got,
                                   input logic [4:0] want);
        if (fail_count < PRINT_LIMIT) begin
            $display("%0t ns: result %0d, %s: got %0d, want %0d",
                     $time, result_count, field, got, want);
        end
        fail_count++;
    endtask

    task automatic place_key_letter(input pf_pkg::letter_t l);
        if (!placed[l] && filled < pf_pkg::CELLS) begin
            square_letter[filled] = l;
            letter_cell[l] = pf_pkg::cell_t'(filled);
            placed[l] = 1'b1;
            // I and J share one cell
            if (l == pf_pkg::LETTER_I || l == pf_pkg::LETTER_J) begin
                placed[pf_pkg::LETTER_I] = 1'b1;
                placed[pf_pkg::LETTER_J] = 1'b1;
                letter_cell[pf_pkg::LETTER_I] = pf_pkg::cell_t'(filled);
                letter_cell[pf_pkg::LETTER_J] = pf_pkg::cell_t'(filled);
            end
            filled++;
        end
    endtask

    function automatic pf_pkg::pf_out_t cipher_pair(input pf_pkg::letter_t a,
                                                    input pf_pkg::letter_t b,
                                                    input logic back);
        int              row_a;
        int              col_a;
        int              row_b;
        int              col_b;
        int              step;
        int              swap;
        pf_pkg::pf_out_t r;
        row_a = int'(letter_cell[a]) / pf_pkg::SIDE;
        col_a = int'(letter_cell[a]) % pf_pkg::SIDE;
        row_b = int'(letter_cell[b]) / pf_pkg::SIDE;
        col_b = int'(letter_cell[b]) % pf_pkg::SIDE;
        step  = back ? pf_pkg::SIDE - 1 : 1;
        if (row_a == row_b) begin
            col_a = (col_a + step) % pf_pkg::SIDE;
            col_b = (col_b + step) % pf_pkg::SIDE;
        end else if (col_a == col_b) begin
            row_a = (row_a + step) % pf_pkg::SIDE;
            row_b = (row_b + step) % pf_pkg::SIDE;
        end else begin
            swap  = col_a;
            col_a = col_b;
            col_b = swap;
        end
        r.out_a  = square_letter[row_a * pf_pkg::SIDE + col_a];
        r.out_b  = square_letter[row_b * pf_pkg::SIDE + col_b];
        r.status = 1'b0;
        return r;
    endfunction

    task automatic apply_item(input pf_pkg::pf_in_t item, output pf_pkg::pf_out_t res);
        pf_pkg::letter_t a;
        pf_pkg::letter_t b;
        a   = (item.letter_a > pf_pkg::LETTER_LAST) ? pf_pkg::LETTER_LAST : item.letter_a;
        b   = (item.letter_b > pf_pkg::LETTER_LAST) ? pf_pkg::LETTER_LAST : item.letter_b;
        res = '0;
        case (item.func)
            pf_pkg::FUNC_CLEAR: begin
                placed      = '0;
                filled      = 0;
                square_done = 1'b0;
            end
            pf_pkg::FUNC_ADD: begin
                if (!square_done) begin
                    place_key_letter(a);
                end
            end
            pf_pkg::FUNC_FINISH: begin
                if (!square_done) begin
                    for (int k = 0; k < pf_pkg::ALPHA; k++) begin
                        place_key_letter(pf_pkg::letter_t'(k));
                    end
                    square_done = 1'b1;
                end
            end
            pf_pkg::FUNC_ENCRYPT, pf_pkg::FUNC_DECRYPT: begin
                if (square_done) begin
                    res = cipher_pair(a, b, item.func == pf_pkg::FUNC_DECRYPT);
                end else begin
                    res.status = 1'b1;
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        pf_pkg::pf_out_t want;
        pf_pkg::pf_out_t got;
        if (!aresetn) begin
            placed      = '0;
            filled      = 0;
            square_done = 1'b0;
            foreach (square_letter[i]) square_letter[i] = '0;
            foreach (letter_cell[i]) letter_cell[i] = '0;
            expected_out.delete();
        end else begin
            if (s_valid && s_ready) begin
                apply_item(s_data, want);
                expected_out.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = m_data;
                result_count++;
                if (expected_out.size() == 0) begin
                    report_mismatch("transaction with nothing outstanding, out_a",
                                    got.out_a, '0);
                end else begin
                    want = expected_out.pop_front();
                    if (got.out_a !== want.out_a) begin
                        report_mismatch("out_a", got.out_a, want.out_a);
                    end
                    if (got.out_b !== want.out_b) begin
                        report_mismatch("out_b", got.out_b, want.out_b);
                    end
                    if (got.status !== want.status) begin
                        report_mismatch("status", 5'(got.status), 5'(want.status));
                    end
                end
            end
        end
        pending = expected_out.size();
    end

endmodule

// File: tb/tb_playfair_digraph_cipher.sv
// Testbench top for the playfair digraph cipher: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_playfair_digraph_cipher;

    localparam pf_pkg::func_t   FUNC_SPARE_FIRST = 3'd5;
    localparam pf_pkg::func_t   FUNC_SPARE_MID   = 3'd6;
    localparam pf_pkg::func_t   FUNC_SPARE_LAST  = 3'd7;
    localparam pf_pkg::letter_t LETTER_CODE_MAX  = 5'd31;
    localparam int              DIRECTED_ITEMS   = 25;
    localparam int              RANDOM_ITEMS     = 1500;
    localparam int              DRAIN_CYCLES     = 40;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    pf_pkg::pf_in_t  s_data = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    pf_pkg::pf_out_t m_data;
    int              fail_count;
    int              pending;
    logic            tx_burst = 1'b0;
    logic            rx_burst = 1'b0;
    int              rx_hold = 0;
    int              sent = 0;
    int              pairs_sent = 0;
    int              squares_built = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    playfair_digraph_cipher dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    playfair_cipher_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(negedge aclk) begin : result_stall
        int pick;
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_ready <= 1'b0;
        end else begin
            pick = $urandom_range(99, 0);
            if (rx_burst || pick < 60) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                rx_hold = (pick < 94) ? $urandom_range(2, 0) : $urandom_range(40, 10);
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(99, 0);
        if (tx_burst || pick < 55) begin
            return 0;
        end
        if (pick < 93) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    function automatic pf_pkg::letter_t any_letter();
        return pf_pkg::letter_t'($urandom_range(LETTER_CODE_MAX, 0));
    endfunction

    function automatic pf_pkg::letter_t pair_letter();
        if ($urandom_range(9, 0) == 0) begin
            return any_letter();
        end
        return pf_pkg::letter_t'($urandom_range(pf_pkg::LETTER_LAST, 0));
    endfunction

    task automatic send_item(input pf_pkg::func_t f, input pf_pkg::letter_t a,
                             input pf_pkg::letter_t b);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= '{func: f, letter_a: a, letter_b: b};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sent++;
        if (f == pf_pkg::FUNC_ENCRYPT || f == pf_pkg::FUNC_DECRYPT) begin
            pairs_sent++;
        end
        if (f == pf_pkg::FUNC_FINISH) begin
            squares_built++;
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // clear, a handful of key letters, sometimes an early pair, finish, then a run of pairs
    task automatic run_key_session();
        pf_pkg::letter_t a;
        pf_pkg::letter_t b;
        send_item(pf_pkg::FUNC_CLEAR, any_letter(), any_letter());
        repeat ($urandom_range(12, 0)) send_item(pf_pkg::FUNC_ADD, any_letter(), any_letter());
        if ($urandom_range(9, 0) == 0) begin
            send_item(pf_pkg::FUNC_ENCRYPT, pair_letter(), pair_letter());
        end
        send_item(pf_pkg::FUNC_FINISH, any_letter(), any_letter());
        repeat ($urandom_range(40, 5)) begin
            a = pair_letter();
            b = ($urandom_range(7, 0) == 0) ? a : pair_letter();
            send_item(($urandom_range(1, 0) == 1) ? pf_pkg::FUNC_DECRYPT : pf_pkg::FUNC_ENCRYPT,
                      a, b);
        end
    endtask

    task automatic run_noise();
        repeat ($urandom_range(8, 1)) begin
            send_item(pf_pkg::func_t'($urandom_range(FUNC_SPARE_LAST, 0)), any_letter(),
                      any_letter());
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_item(pf_pkg::FUNC_ENCRYPT, 5'd0, pf_pkg::LETTER_LAST);
        send_item(pf_pkg::FUNC_DECRYPT, LETTER_CODE_MAX, LETTER_CODE_MAX);
        send_item(FUNC_SPARE_LAST, LETTER_CODE_MAX, LETTER_CODE_MAX);
        send_item(FUNC_SPARE_FIRST, 5'd0, 5'd0);
        send_item(pf_pkg::FUNC_ADD, 5'd15, 5'd0);
        send_item(pf_pkg::FUNC_ADD, 5'd11, 5'd0);
        send_item(pf_pkg::FUNC_ADD, 5'd0, 5'd0);
        send_item(pf_pkg::FUNC_ADD, 5'd24, 5'd0);
        send_item(pf_pkg::FUNC_ADD, 5'd5, 5'd0);
        send_item(pf_pkg::FUNC_ADD, pf_pkg::LETTER_J, 5'd0);
        send_item(pf_pkg::FUNC_ADD, pf_pkg::LETTER_I, 5'd0);
        send_item(pf_pkg::FUNC_ADD, 5'd0, 5'd0);
        send_item(pf_pkg::FUNC_ADD, LETTER_CODE_MAX, 5'd0);
        send_item(pf_pkg::FUNC_FINISH, 5'd0, 5'd0);
        send_item(pf_pkg::FUNC_FINISH, 5'd0, 5'd0);
        send_item(pf_pkg::FUNC_ADD, 5'd1, 5'd0);
        send_item(pf_pkg::FUNC_ENCRYPT, 5'd15, 5'd11);
        send_item(pf_pkg::FUNC_DECRYPT, 5'd15, 5'd0);
        send_item(pf_pkg::FUNC_ENCRYPT, 5'd15, 5'd4);
        send_item(pf_pkg::FUNC_DECRYPT, pf_pkg::LETTER_I, pf_pkg::LETTER_J);
        send_item(pf_pkg::FUNC_ENCRYPT, 5'd0, 5'd23);
        send_item(pf_pkg::FUNC_DECRYPT, LETTER_CODE_MAX, 5'd3);
        send_item(pf_pkg::FUNC_ENCRYPT, 5'd19, 5'd15);
        send_item(FUNC_SPARE_MID, 5'd0, LETTER_CODE_MAX);
        send_item(pf_pkg::FUNC_CLEAR, 5'd0, 5'd0);
        wait_drained();

        while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            tx_burst = ($urandom_range(5, 0) == 0);
            rx_burst = ($urandom_range(5, 0) == 0);
            if ($urandom_range(9, 0) < 8) begin
                run_key_session();
            end else begin
                run_noise();
            end
            if ($urandom_range(7, 0) == 0) begin
                wait_drained();
            end
        end

        rx_burst = 1'b0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d transactions: %0d finished key squares, %0d pairs,",
                 sent, squares_built, pairs_sent);
        $display("early pairs, repeated and late key letters, I/J cells and unused codes.");
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
